### hdl/csmv_pkg.sv
// shared types and constants for the coo sparse matrix-vector accumulate block
`default_nettype none
package csmv_pkg;

	localparam int ROW_W      = 10;
	localparam int COL_W      = 10;
	localparam int VAL_W      = 32;
	localparam int ACC_W      = 48;
	localparam int PROD_W     = 2 * VAL_W;
	localparam int FRAC_W     = 16;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int STATUS_W   = 2;
	localparam int OP_W       = 2;

	localparam int MAX_ROWS   = 1024;
	localparam int MAX_COLS   = 1024;
	localparam int ROW_AW     = $clog2(MAX_ROWS);
	localparam int COL_AW     = $clog2(MAX_COLS);
	localparam int CLR_W      = ROW_AW + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [CFG_W-1:0] NUM_ROWS_RESET = CFG_W'(MAX_ROWS);
	localparam logic [CFG_W-1:0] NUM_COLS_RESET = CFG_W'(MAX_COLS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_index_t;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 2'd0,
		OP_MAC  = 2'd1,
		OP_READ = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_SAT   = 2'd2
	} status_t;

	// what the back end has to do with a queued item
	typedef enum logic [2:0] {
		CMD_LOAD,
		CMD_MAC,
		CMD_READ,
		CMD_RANGE,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [VAL_W-1:0]  value;
	} cmd_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_MUL,
		BS_RND,
		BS_DONE
	} back_state_t;

endpackage
`default_nettype wire

### hdl/csmv_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module csmv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hdl/csmv_front.sv
// front end: config registers, index checks and the command queue
`default_nettype none
module csmv_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	input  wire logic [csmv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [csmv_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [csmv_pkg::OP_W-1:0]       op,
	input  wire logic [csmv_pkg::ROW_W-1:0]      row_index,
	input  wire logic [csmv_pkg::COL_W-1:0]      col_index,
	input  wire logic [csmv_pkg::VAL_W-1:0]      value,
	input  wire logic                            clearing,
	output logic                                 q_valid,
	output csmv_pkg::cmd_t                       q_head,
	input  wire logic                            q_pop
);

	logic [csmv_pkg::CFG_W-1:0]  num_rows_q;
	logic [csmv_pkg::CFG_W-1:0]  num_cols_q;
	csmv_pkg::cmd_t              q_mem_q [csmv_pkg::QUEUE_DEPTH];
	logic [csmv_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [csmv_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [csmv_pkg::QCNT_W-1:0] count_q;
	logic                        row_ok;
	logic                        col_ok;
	logic                        push;
	csmv_pkg::cmd_t              new_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= csmv_pkg::NUM_ROWS_RESET;
			num_cols_q <= csmv_pkg::NUM_COLS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				csmv_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data;
				csmv_pkg::REG_NUM_COLS: num_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		row_ok = ({1'b0, row_index} < num_rows_q) && (int'(row_index) < csmv_pkg::MAX_ROWS);
		col_ok = ({1'b0, col_index} < num_cols_q) && (int'(col_index) < csmv_pkg::MAX_COLS);
		new_cmd.row   = row_index;
		new_cmd.col   = col_index;
		new_cmd.value = value;
		case (op)
			csmv_pkg::OP_LOAD: new_cmd.kind = col_ok ? csmv_pkg::CMD_LOAD : csmv_pkg::CMD_RANGE;
			csmv_pkg::OP_MAC:  new_cmd.kind = (row_ok && col_ok) ? csmv_pkg::CMD_MAC
							: csmv_pkg::CMD_RANGE;
			csmv_pkg::OP_READ: new_cmd.kind = row_ok ? csmv_pkg::CMD_READ : csmv_pkg::CMD_RANGE;
			default:           new_cmd.kind = csmv_pkg::CMD_NOP;
		endcase
	end

	// no new items while the queue is full or the accumulator clear pass runs
	assign in_stall = (count_q == csmv_pkg::QCNT_W'(csmv_pkg::QUEUE_DEPTH)) || clearing;
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_head   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/csmv_back.sv
// back end: vector and accumulator rams, multiply, accumulate and result register
`default_nettype none
module csmv_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_valid,
	input  wire csmv_pkg::cmd_t                 q_head,
	output logic                                q_pop,
	output logic                                clearing,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [csmv_pkg::STATUS_W-1:0]       status,
	output logic [csmv_pkg::ROW_W-1:0]          result_row,
	output logic [csmv_pkg::VAL_W-1:0]          result_value
);

	csmv_pkg::back_state_t          state_q;
	csmv_pkg::back_state_t          state_d;
	logic [csmv_pkg::CLR_W-1:0]     clr_cnt_q;
	csmv_pkg::cmd_t                 cmd_q;
	logic signed [csmv_pkg::PROD_W-1:0] prod_q;
	logic signed [csmv_pkg::ACC_W-1:0]  mac_q;
	logic signed [csmv_pkg::ACC_W-1:0]  acc_q;
	logic [csmv_pkg::VAL_W-1:0]     vec_rdata;
	logic [csmv_pkg::ACC_W-1:0]     acc_rdata;
	logic                           vec_we;
	logic                           acc_we;
	logic [csmv_pkg::ROW_AW-1:0]    acc_waddr;
	logic [csmv_pkg::ACC_W-1:0]     acc_wdata;
	logic                           done;
	logic signed [csmv_pkg::PROD_W-1:0] prod_rnd;
	logic signed [csmv_pkg::ACC_W:0]    sum_wide;
	logic signed [csmv_pkg::ACC_W-1:0]  sum_sat;
	logic                           sum_ovf;
	logic [csmv_pkg::VAL_W-1:0]     rd_sat;
	logic                           rd_ovf;
	logic                           out_valid_q;
	logic [csmv_pkg::STATUS_W-1:0]  status_q;
	logic [csmv_pkg::ROW_W-1:0]     result_row_q;
	logic [csmv_pkg::VAL_W-1:0]     result_value_q;
	csmv_pkg::status_t              status_d;
	logic [csmv_pkg::ROW_W-1:0]     row_d;
	logic [csmv_pkg::VAL_W-1:0]     val_d;

	assign clearing = (clr_cnt_q != csmv_pkg::CLR_W'(csmv_pkg::MAX_ROWS));

	csmv_ram #(
		.WIDTH (csmv_pkg::VAL_W),
		.DEPTH (csmv_pkg::MAX_COLS)
	) u_vec_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (cmd_q.col[csmv_pkg::COL_AW-1:0]),
		.wdata (cmd_q.value),
		.raddr (q_head.col[csmv_pkg::COL_AW-1:0]),
		.rdata (vec_rdata)
	);

	csmv_ram #(
		.WIDTH (csmv_pkg::ACC_W),
		.DEPTH (csmv_pkg::MAX_ROWS)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (q_head.row[csmv_pkg::ROW_AW-1:0]),
		.rdata (acc_rdata)
	);

	// product truncated toward zero: bias negatives before the arithmetic shift
	always_comb begin
		prod_rnd = prod_q;
		if (prod_q[csmv_pkg::PROD_W-1]) begin
			prod_rnd = prod_q + csmv_pkg::PROD_W'((1 << csmv_pkg::FRAC_W) - 1);
		end
		prod_rnd = prod_rnd >>> csmv_pkg::FRAC_W;
	end

	always_comb begin
		sum_wide = {acc_q[csmv_pkg::ACC_W-1], acc_q} + {mac_q[csmv_pkg::ACC_W-1], mac_q};
		sum_ovf  = sum_wide[csmv_pkg::ACC_W] != sum_wide[csmv_pkg::ACC_W-1];
		sum_sat  = sum_wide[csmv_pkg::ACC_W-1:0];
		if (sum_ovf) begin
			sum_sat = sum_wide[csmv_pkg::ACC_W] ? {1'b1, {(csmv_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(csmv_pkg::ACC_W-1){1'b1}}};
		end
		// read-out clamp: upper bits must all match the 32-bit sign
		rd_ovf = (acc_q[csmv_pkg::ACC_W-1:csmv_pkg::VAL_W-1] != '0)
			&& (acc_q[csmv_pkg::ACC_W-1:csmv_pkg::VAL_W-1] != '1);
		rd_sat = acc_q[csmv_pkg::VAL_W-1:0];
		if (rd_ovf) begin
			rd_sat = acc_q[csmv_pkg::ACC_W-1] ? {1'b1, {(csmv_pkg::VAL_W-1){1'b0}}}
				: {1'b0, {(csmv_pkg::VAL_W-1){1'b1}}};
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		done      = 1'b0;
		vec_we    = 1'b0;
		acc_we    = 1'b0;
		acc_waddr = cmd_q.row[csmv_pkg::ROW_AW-1:0];
		acc_wdata = '0;
		status_d  = csmv_pkg::STATUS_OK;
		row_d     = '0;
		val_d     = '0;
		case (state_q)
			csmv_pkg::BS_IDLE: begin
				if (q_valid && !clearing) begin
					q_pop   = 1'b1;
					state_d = csmv_pkg::BS_MUL;
				end
			end
			csmv_pkg::BS_MUL: state_d = csmv_pkg::BS_RND;
			csmv_pkg::BS_RND: state_d = csmv_pkg::BS_DONE;
			csmv_pkg::BS_DONE: begin
				if (!out_valid_q || !out_stall) begin
					done    = 1'b1;
					state_d = csmv_pkg::BS_IDLE;
				end
			end
			default: state_d = csmv_pkg::BS_IDLE;
		endcase
		case (cmd_q.kind)
			csmv_pkg::CMD_LOAD: vec_we = done;
			csmv_pkg::CMD_MAC: begin
				acc_we    = done;
				acc_wdata = sum_sat;
				status_d  = sum_ovf ? csmv_pkg::STATUS_SAT : csmv_pkg::STATUS_OK;
			end
			csmv_pkg::CMD_READ: begin
				acc_we   = done;
				status_d = rd_ovf ? csmv_pkg::STATUS_SAT : csmv_pkg::STATUS_OK;
				row_d    = cmd_q.row;
				val_d    = rd_sat;
			end
			csmv_pkg::CMD_RANGE: status_d = csmv_pkg::STATUS_RANGE;
			default: ;
		endcase
		if (clearing) begin
			acc_we    = 1'b1;
			acc_waddr = clr_cnt_q[csmv_pkg::ROW_AW-1:0];
			acc_wdata = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= csmv_pkg::BS_IDLE;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (state_q == csmv_pkg::BS_MUL) begin
			prod_q <= $signed(cmd_q.value) * $signed(vec_rdata);
			acc_q  <= $signed(acc_rdata);
		end
		if (state_q == csmv_pkg::BS_RND) begin
			mac_q <= prod_rnd[csmv_pkg::ACC_W-1:0];
		end
		if (done) begin
			status_q       <= status_d;
			result_row_q   <= row_d;
			result_value_q <= val_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign result_row   = result_row_q;
	assign result_value = result_value_q;

endmodule
`default_nettype wire

### hdl/coo_sparse_matvec_accumulate.sv
// top level of the coo sparse matrix-vector accumulate block
// usage:
//   input channel (in_valid / in_stall) takes one transaction per item: op, row_index,
//   col_index and value. op 0 loads a vector element, op 1 adds value * x[col] into
//   the row accumulator, op 2 reads the row sum (saturated to 32 bits) and clears it.
//   every item yields exactly one result transaction on the output channel
//   (out_valid / out_stall) carrying status, result_row and result_value.
//   config channel (cfg_valid / cfg_ready) writes num_rows (index 0) and num_cols
//   (index 1); cfg_ready is always high. the user makes writes only while the block
//   is idle; the block itself does not enforce it. the back end sequencer (ram read,
//   32x32 multiply, rounding, accumulate and write) works on one item at a time and
//   pops the next item from the queue only when the last one is done. a 4-entry queue
//   lets the input side keep taking items while the back end works or the result
//   waits.
//   reset: config goes to 1024 rows and columns, then a clear pass zeroes the
//   1024 accumulators, one per cycle; in_stall is high for the whole pass.
//   the vector store is not cleared and must be loaded before use.
//   when the receiver stalls, the result register holds, the back end waits, the
//   queue fills and in_stall rises.
`default_nettype none
module coo_sparse_matvec_accumulate (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [csmv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [csmv_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [csmv_pkg::OP_W-1:0]       op,
	input  wire logic [csmv_pkg::ROW_W-1:0]      row_index,
	input  wire logic [csmv_pkg::COL_W-1:0]      col_index,
	input  wire logic [csmv_pkg::VAL_W-1:0]      value,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [csmv_pkg::STATUS_W-1:0]        status,
	output logic [csmv_pkg::ROW_W-1:0]           result_row,
	output logic [csmv_pkg::VAL_W-1:0]           result_value
);

	logic           q_valid;
	csmv_pkg::cmd_t q_head;
	logic           q_pop;
	logic           clearing;

	assign cfg_ready = 1'b1;

	csmv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.clearing  (clearing),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	csmv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.clearing     (clearing),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_row   (result_row),
		.result_value (result_value)
	);

endmodule
`default_nettype wire

### bench/tb_coo_sparse_matvec_accumulate.sv
// testbench for the coo sparse matrix-vector accumulate block: predicting scoreboard, random stalls
`timescale 1ns / 1ps
module tb_coo_sparse_matvec_accumulate;
	import csmv_pkg::*;

	localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
	localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
	localparam longint PROD_SCALE = longint'(1) << FRAC_W;
	localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -(longint'(1) << (ACC_W - 1));
	localparam longint SUM_HI = (longint'(1) << (VAL_W - 1)) - 1;
	localparam longint SUM_LO = -(longint'(1) << (VAL_W - 1));
	localparam int NUM_PHASES       = 7;
	localparam int RANDOM_PER_PHASE = 72;
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int DRAIN_CYCLES     = 20;

	typedef struct {
		status_t           status;
		logic [ROW_W-1:0]  row;
		logic [VAL_W-1:0]  value;
	} mv_result_t;

	class matvec_scoreboard;
		logic [CFG_W-1:0]        num_rows;
		logic [CFG_W-1:0]        num_cols;
		logic signed [VAL_W-1:0] x_store [MAX_COLS];
		bit                      x_loaded [MAX_COLS];
		logic signed [ACC_W-1:0] row_acc [MAX_ROWS];
		mv_result_t              expected_results [$];
		int                      mismatches;

		function new();
			num_rows = NUM_ROWS_RESET;
			num_cols = NUM_COLS_RESET;
			foreach (row_acc[i]) row_acc[i] = '0;
			foreach (x_loaded[i]) x_loaded[i] = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
			if (idx == REG_NUM_ROWS)
				num_rows = data;
			else
				num_cols = data;
		endfunction

		function bit row_ok(logic [ROW_W-1:0] row_idx);
			return row_idx < num_rows && row_idx < MAX_ROWS;
		endfunction

		function bit col_ok(logic [COL_W-1:0] col_idx);
			return col_idx < num_cols && col_idx < MAX_COLS;
		endfunction

		function mv_result_t predict_item(logic [OP_W-1:0] op_code, logic [ROW_W-1:0] row_idx,
				logic [COL_W-1:0] col_idx, logic signed [VAL_W-1:0] val);
			mv_result_t res;
			longint prod;
			longint sum;
			res.status = STATUS_OK;
			res.row = '0;
			res.value = '0;
			case (op_code)
				OP_LOAD: begin
					if (col_ok(col_idx)) begin
						x_store[col_idx] = val;
						x_loaded[col_idx] = 1'b1;
					end else
						res.status = STATUS_RANGE;
				end
				OP_MAC: begin
					if (row_ok(row_idx) && col_ok(col_idx)) begin
						// q32.32 product, fraction cut to 16 bits toward zero
						prod = (longint'(val) * longint'(x_store[col_idx])) / PROD_SCALE;
						sum = longint'(row_acc[row_idx]) + prod;
						if (sum > ACC_HI) begin
							sum = ACC_HI;
							res.status = STATUS_SAT;
						end else if (sum < ACC_LO) begin
							sum = ACC_LO;
							res.status = STATUS_SAT;
						end
						row_acc[row_idx] = ACC_W'(sum);
					end else
						res.status = STATUS_RANGE;
				end
				OP_READ: begin
					if (row_ok(row_idx)) begin
						sum = longint'(row_acc[row_idx]);
						if (sum > SUM_HI) begin
							sum = SUM_HI;
							res.status = STATUS_SAT;
						end else if (sum < SUM_LO) begin
							sum = SUM_LO;
							res.status = STATUS_SAT;
						end
						res.row = row_idx;
						res.value = VAL_W'(sum);
						row_acc[row_idx] = '0;
					end else
						res.status = STATUS_RANGE;
				end
				default: ;
			endcase
			return res;
		endfunction

		function void note_input(logic [OP_W-1:0] op_code, logic [ROW_W-1:0] row_idx,
				logic [COL_W-1:0] col_idx, logic [VAL_W-1:0] val);
			expected_results.push_back(predict_item(op_code, row_idx, col_idx, val));
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [ROW_W-1:0] row_idx,
				logic [VAL_W-1:0] val);
			mv_result_t want;
			if (expected_results.size() == 0) begin
				$error("result transaction with nothing outstanding: status %0d row %0d value 0x%08h",
					st, row_idx, val);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				mismatches++;
			end
			if (row_idx !== want.row) begin
				$error("result_row: expected %0d, actual %0d", want.row, row_idx);
				mismatches++;
			end
			if (val !== want.value) begin
				$error("result_value: expected 0x%08h, actual 0x%08h", want.value, val);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       op = '0;
	logic [ROW_W-1:0]      row_index = '0;
	logic [COL_W-1:0]      col_index = '0;
	logic [VAL_W-1:0]      value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [ROW_W-1:0]      result_row;
	logic [VAL_W-1:0]      result_value;

	bit send_burst = 1'b0;
	bit recv_burst = 1'b0;
	int quiet_cycles = 0;
	matvec_scoreboard sb;

	coo_sparse_matvec_accumulate u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.row_index    (row_index),
		.col_index    (col_index),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.result_row   (result_row),
		.result_value (result_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// called at a falling edge, returns at the falling edge after the transaction
	task automatic send_item(logic [OP_W-1:0] op_code, logic [ROW_W-1:0] row_idx,
			logic [COL_W-1:0] col_idx, logic [VAL_W-1:0] val);
		int gap;
		if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			if (in_valid) in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= op_code;
		row_index <= row_idx;
		col_index <= col_idx;
		value <= val;
		do @(posedge clk); while (in_stall);
		sb.note_input(op_code, row_idx, col_idx, val);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		if (in_valid) in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	task automatic write_config(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
		cfg_valid <= 1'b1;
		cfg_index <= REG_NUM_ROWS;
		cfg_data <= rows;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_NUM_ROWS, rows);
		@(negedge clk);
		cfg_index <= REG_NUM_COLS;
		cfg_data <= cols;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(REG_NUM_COLS, cols);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly in range, hot rows get picked often so sums build up
	function automatic logic [ROW_W-1:0] pick_index(int lim, bit hot);
		int roll;
		roll = $urandom_range(0, 9);
		if (lim == 0 || roll == 0) return ROW_W'($urandom);
		if (hot && roll < 6) return ROW_W'($urandom_range(0, (lim < 4 ? lim : 4) - 1));
		return ROW_W'($urandom_range(0, lim - 1));
	endfunction

	task automatic send_random(int n_items);
		int sent;
		int pick;
		int tries;
		int row_lim;
		int col_lim;
		logic [OP_W-1:0]  op_code;
		logic [ROW_W-1:0] row_idx;
		logic [COL_W-1:0] col_idx;
		logic [VAL_W-1:0] val;
		sent = 0;
		row_lim = (sb.num_rows > MAX_ROWS) ? MAX_ROWS : sb.num_rows;
		col_lim = (sb.num_cols > MAX_COLS) ? MAX_COLS : sb.num_cols;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				op_code = OP_UNUSED;
			else if (pick < 30)
				op_code = OP_LOAD;
			else if (pick < 80)
				op_code = OP_MAC;
			else
				op_code = OP_READ;
			row_idx = pick_index(row_lim, 1'b1);
			col_idx = pick_index(col_lim, 1'b0);
			case ($urandom_range(0, 9))
				0: val = VAL_MAX;
				1: val = VAL_MIN;
				2: val = '0;
				3, 4: val = VAL_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
				default: val = $urandom;
			endcase
			// never multiply by a vector element that was not loaded
			if (op_code == OP_MAC && sb.row_ok(row_idx) && sb.col_ok(col_idx)) begin
				tries = 0;
				while (!sb.x_loaded[col_idx] && tries < 8) begin
					col_idx = COL_W'($urandom_range(0, col_lim - 1));
					tries++;
				end
				if (!sb.x_loaded[col_idx]) op_code = OP_LOAD;
			end
			send_item(op_code, row_idx, col_idx, val);
			if (op_code != OP_UNUSED) sent++;
		end
	endtask

	// receiver: random stall before each result transaction
	initial begin
		int hold;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
			hold = recv_burst ? 0 : $urandom_range(0, 10);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(status, result_row, result_value);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_coo_sparse_matvec_accumulate: FAIL");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] phase_rows [NUM_PHASES];
		logic [CFG_W-1:0] phase_cols [NUM_PHASES];
		sb = new();
		phase_rows = '{11'd1024, 11'd1, 11'd16, 11'd0, 11'd2047, 11'd1, 11'd1024};
		phase_cols = '{11'd1024, 11'd1, 11'd4, 11'd2047, 11'd0, 11'd1, 11'd1024};
		phase_rows[5] = CFG_W'($urandom_range(1, 1024));
		phase_cols[5] = CFG_W'($urandom_range(1, 1024));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// accumulator clear pass runs with in_stall high
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			write_config(phase_rows[p], phase_cols[p]);
			if (p == 0) begin
				send_item(OP_LOAD, 10'd0, 10'd0, VAL_MAX);
				send_item(OP_LOAD, 10'd0, 10'd1023, VAL_MIN);
				send_item(OP_LOAD, 10'd0, 10'd5, 32'h0001_0000);
				send_item(OP_LOAD, 10'd0, 10'd6, 32'hFFFF_0000);
				send_item(OP_LOAD, 10'd0, 10'd7, 32'hFFFF_FFFF);
				send_item(OP_MAC, 10'd0, 10'd5, 32'h0001_8000);
				send_item(OP_MAC, 10'd0, 10'd6, 32'h0000_8000);
				// negative product below one lsb truncates to zero, not minus one
				send_item(OP_MAC, 10'd1, 10'd7, 32'h0000_8000);
				send_item(OP_MAC, 10'd1, 10'd7, 32'h0003_0000);
				send_item(OP_MAC, 10'd2, 10'd0, VAL_MAX);
				send_item(OP_READ, 10'd2, 10'd0, '0);
				// two min*min products overflow the 48-bit accumulator
				send_item(OP_MAC, 10'd3, 10'd1023, VAL_MIN);
				send_item(OP_MAC, 10'd3, 10'd1023, VAL_MIN);
				send_item(OP_READ, 10'd3, 10'd0, '0);
				send_item(OP_MAC, 10'd4, 10'd1023, VAL_MAX);
				send_item(OP_MAC, 10'd4, 10'd1023, VAL_MAX);
				send_item(OP_MAC, 10'd4, 10'd1023, VAL_MAX);
				send_item(OP_READ, 10'd4, 10'd0, '0);
				send_item(OP_READ, 10'd0, 10'd0, '0);
				send_item(OP_READ, 10'd0, 10'd0, '0);
				send_item(OP_READ, 10'd1, 10'd0, '0);
				send_item(OP_UNUSED, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
				send_item(OP_MAC, 10'd1023, 10'd1023, '0);
				send_item(OP_READ, 10'd1023, 10'h3FF, 32'hFFFF_FFFF);
			end
			send_random(RANDOM_PER_PHASE);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_coo_sparse_matvec_accumulate: PASS");
		else
			$display("tb_coo_sparse_matvec_accumulate: FAIL");
		$finish;
	end

endmodule

### filelist.f
hdl/csmv_pkg.sv
hdl/csmv_ram.sv
hdl/csmv_front.sv
hdl/csmv_back.sv
hdl/coo_sparse_matvec_accumulate.sv
bench/tb_coo_sparse_matvec_accumulate.sv
